// ===== rtl/cle_pkg.sv =====
// cle_pkg: shared widths, request/status codes, state and command types for
// the convolution-layer engine. No dependencies; compiled first.

package cle_pkg;

   // Field widths, fixed by the request/response formats
   localparam int TYPE_W   = 2;
   localparam int ADDR_W   = 14;
   localparam int WORD_W   = 16;
   localparam int MAP_W    = 4;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 5;
   localparam int STRIDE_W = 3;
   localparam int SCALED_W = STRIDE_W + ROW_W;

   // Request kinds
   localparam logic [TYPE_W-1:0] REQ_LOAD_PIXEL  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD_WEIGHT = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COMPUTE     = 2'd2;

   // Response status
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Stride register limits and reset
   localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 3'd1;
   localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 3'd4;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 3'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // How the input pointer moves after a tap
   typedef enum logic [1:0] {
      STEP_NEXT_COL,
      STEP_NEXT_ROW,
      STEP_NEXT_CHAN
   } step_type;

   typedef struct packed {
      logic     load_pixel;
      logic     load_weight;
      logic     capture;
      logic     setup;
      logic     base;
      logic     issue;
      step_type step;
      logic     finish;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/cle_if.sv =====
// cle_if: valid/ready channel interfaces for requests and responses.
// Depends on cle_pkg for field widths.

interface cle_req_if;
   logic                                valid;
   logic                                ready;
   logic [cle_pkg::TYPE_W-1:0]          req_type;
   logic [cle_pkg::ADDR_W-1:0]          address;
   logic signed [cle_pkg::WORD_W-1:0]   value;
   logic [cle_pkg::MAP_W-1:0]           out_map;
   logic [cle_pkg::ROW_W-1:0]           out_row;
   logic [cle_pkg::COL_W-1:0]           out_col;

   modport source (output valid, req_type, address, value, out_map, out_row, out_col,
                   input ready);
   modport sink (input valid, req_type, address, value, out_map, out_row, out_col,
                 output ready);
endinterface

interface cle_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cle_pkg::WORD_W-1:0]   result;
   logic                                status;

   modport source (output valid, result, status, input ready);
   modport sink (input valid, result, status, output ready);
endinterface

// ===== rtl/cle_ctrl.sv =====
// cle_ctrl: sequencer for the convolution engine. Walks the kernel taps of a
// compute request and drives the datapath commands. Depends on cle_pkg.

module cle_ctrl #(
   parameter int IN_CHANNELS = 16,
   parameter int KERNEL      = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [cle_pkg::TYPE_W-1:0]  req_type,
   output logic                        req_ready,
   input  cle_pkg::stat_type           stat,
   output cle_pkg::cmd_type            cmd
);

   localparam int TAPS  = IN_CHANNELS * KERNEL * KERNEL;
   localparam int K_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   cle_pkg::state_type state_ff, state_in;
   logic [K_W-1:0]     kj_ff, kj_in;
   logic [K_W-1:0]     ki_ff, ki_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic               accept;
   logic               kj_last;
   logic               ki_last;
   logic               tap_last;

   assign accept   = req_valid && req_ready;
   assign kj_last  = (kj_ff == K_W'(KERNEL - 1));
   assign ki_last  = (ki_ff == K_W'(KERNEL - 1));
   assign tap_last = (tap_ff == TAP_W'(TAPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            if (accept && req_type == cle_pkg::REQ_COMPUTE) state_in = cle_pkg::ST_SETUP;
         end
         cle_pkg::ST_SETUP: begin
            state_in = stat.range_ok ? cle_pkg::ST_BASE : cle_pkg::ST_FINISH;
         end
         cle_pkg::ST_BASE: begin
            state_in = cle_pkg::ST_RUN;
         end
         cle_pkg::ST_RUN: begin
            if (tap_last) state_in = cle_pkg::ST_DRAIN;
         end
         cle_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = cle_pkg::ST_FINISH;
         end
         cle_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = cle_pkg::ST_IDLE;
         end
         default: state_in = cle_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.step        = cle_pkg::STEP_NEXT_COL;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_pixel  = req_valid && (req_type == cle_pkg::REQ_LOAD_PIXEL);
            cmd.load_weight = req_valid && (req_type == cle_pkg::REQ_LOAD_WEIGHT);
            cmd.capture     = req_valid && (req_type == cle_pkg::REQ_COMPUTE);
         end
         cle_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         cle_pkg::ST_BASE: begin
            cmd.base = 1'b1;
         end
         cle_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (!kj_last) cmd.step = cle_pkg::STEP_NEXT_COL;
            else if (!ki_last) cmd.step = cle_pkg::STEP_NEXT_ROW;
            else cmd.step = cle_pkg::STEP_NEXT_CHAN;
         end
         cle_pkg::ST_DRAIN: begin
         end
         cle_pkg::ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   // tap counters
   always_comb begin
      kj_in  = kj_ff;
      ki_in  = ki_ff;
      tap_in = tap_ff;
      if (state_ff == cle_pkg::ST_BASE) begin
         kj_in  = '0;
         ki_in  = '0;
         tap_in = '0;
      end else if (state_ff == cle_pkg::ST_RUN) begin
         tap_in = tap_ff + TAP_W'(1);
         if (kj_last) begin
            kj_in = '0;
            ki_in = ki_last ? '0 : ki_ff + K_W'(1);
         end else begin
            kj_in = kj_ff + K_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::ST_IDLE;
         kj_ff    <= '0;
         ki_ff    <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kj_ff    <= kj_in;
         ki_ff    <= ki_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

// ===== rtl/cle_datapath.sv =====
// cle_datapath: pixel and weight stores, address pointers, MAC pipeline,
// stride register and response register. Depends on cle_pkg.

module cle_datapath #(
   parameter int IN_CHANNELS = 16,
   parameter int OUT_MAPS    = 16,
   parameter int KERNEL      = 3,
   parameter int IN_ROWS     = 32,
   parameter int IN_COLS     = 32,
   parameter int DATA_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cle_pkg::cmd_type                    cmd,
   output cle_pkg::stat_type                   stat,
   input  logic                                csr_we,
   input  logic [cle_pkg::STRIDE_W-1:0]        csr_wdata,
   input  logic [cle_pkg::ADDR_W-1:0]          req_address,
   input  logic signed [cle_pkg::WORD_W-1:0]   req_value,
   input  logic [cle_pkg::MAP_W-1:0]           req_out_map,
   input  logic [cle_pkg::ROW_W-1:0]           req_out_row,
   input  logic [cle_pkg::COL_W-1:0]           req_out_col,
   output logic                                rsp_valid,
   output logic signed [cle_pkg::WORD_W-1:0]   rsp_result,
   output logic                                rsp_status,
   input  logic                                rsp_ready
);

   localparam int TAPS      = IN_CHANNELS * KERNEL * KERNEL;
   localparam int IN_DEPTH  = IN_CHANNELS * IN_ROWS * IN_COLS;
   localparam int WGT_DEPTH = OUT_MAPS * TAPS;
   localparam int SPACE     = 2 ** cle_pkg::ADDR_W;

   localparam int IN_MEM_DEPTH  = (IN_DEPTH < SPACE) ? IN_DEPTH : SPACE;
   localparam int WGT_MEM_DEPTH = (WGT_DEPTH < SPACE) ? WGT_DEPTH : SPACE;
   localparam int IN_AW  = (IN_MEM_DEPTH > 1) ? $clog2(IN_MEM_DEPTH) : 1;
   localparam int WGT_AW = (WGT_MEM_DEPTH > 1) ? $clog2(WGT_MEM_DEPTH) : 1;
   localparam int IN_PW  = $clog2(IN_DEPTH + 1);
   localparam int WGT_PW = $clog2(WGT_DEPTH + 1);

   // pointer jumps at the end of a kernel row and of a channel
   localparam int ROW_JUMP  = IN_COLS - (KERNEL - 1);
   localparam int CHAN_JUMP = IN_ROWS * IN_COLS - (KERNEL - 1) * IN_COLS - (KERNEL - 1);

   // output extents per stride
   localparam int ROWS_S1 = (IN_ROWS >= KERNEL) ? (IN_ROWS - KERNEL) / 1 + 1 : 0;
   localparam int ROWS_S2 = (IN_ROWS >= KERNEL) ? (IN_ROWS - KERNEL) / 2 + 1 : 0;
   localparam int ROWS_S3 = (IN_ROWS >= KERNEL) ? (IN_ROWS - KERNEL) / 3 + 1 : 0;
   localparam int ROWS_S4 = (IN_ROWS >= KERNEL) ? (IN_ROWS - KERNEL) / 4 + 1 : 0;
   localparam int COLS_S1 = (IN_COLS >= KERNEL) ? (IN_COLS - KERNEL) / 1 + 1 : 0;
   localparam int COLS_S2 = (IN_COLS >= KERNEL) ? (IN_COLS - KERNEL) / 2 + 1 : 0;
   localparam int COLS_S3 = (IN_COLS >= KERNEL) ? (IN_COLS - KERNEL) / 3 + 1 : 0;
   localparam int COLS_S4 = (IN_COLS >= KERNEL) ? (IN_COLS - KERNEL) / 4 + 1 : 0;
   localparam int EXT_MAX = (IN_ROWS > IN_COLS) ? IN_ROWS : IN_COLS;
   localparam int EXT_CW  = ($clog2(EXT_MAX + 1) > cle_pkg::ROW_W) ?
                            $clog2(EXT_MAX + 1) : cle_pkg::ROW_W;
   localparam int MAP_CW  = ($clog2(OUT_MAPS + 1) > cle_pkg::MAP_W) ?
                            $clog2(OUT_MAPS + 1) : cle_pkg::MAP_W;

   logic [cle_pkg::WORD_W-1:0] in_mem  [IN_MEM_DEPTH];
   logic [cle_pkg::WORD_W-1:0] wgt_mem [WGT_MEM_DEPTH];

   logic [cle_pkg::STRIDE_W-1:0] stride_ff;
   logic [cle_pkg::STRIDE_W-1:0] eff_stride;
   logic [cle_pkg::MAP_W-1:0]    map_ff;
   logic [cle_pkg::ROW_W-1:0]    row_ff;
   logic [cle_pkg::COL_W-1:0]    col_ff;
   logic [cle_pkg::SCALED_W-1:0] srow_ff, scol_ff;
   logic                         ok_ff;
   logic [EXT_CW-1:0]            rows_ext, cols_ext;

   logic [IN_PW-1:0]             ia_ff, ia_in;
   logic [WGT_PW-1:0]            wa_ff, wa_in;

   logic                         rd_vld_ff, mul_vld_ff;
   logic signed [cle_pkg::WORD_W-1:0] x_ff, w_ff;
   logic [DATA_BITS-1:0]         prod_ff;
   logic [DATA_BITS-1:0]         acc_ff, acc_in;
   logic signed [31:0]           acc_wide;
   logic signed [31:0]           product;

   logic                         rsp_valid_ff;
   logic signed [cle_pkg::WORD_W-1:0] rsp_result_ff;
   logic                         rsp_status_ff;

   // stride register, out-of-range values clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= cle_pkg::STRIDE_RESET;
      end else if (csr_we) begin
         stride_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (stride_ff < cle_pkg::STRIDE_MIN) eff_stride = cle_pkg::STRIDE_MIN;
      else if (stride_ff > cle_pkg::STRIDE_MAX) eff_stride = cle_pkg::STRIDE_MAX;
      else eff_stride = stride_ff;
   end

   always_comb begin
      case (eff_stride)
         3'd1: begin
            rows_ext = EXT_CW'(ROWS_S1);
            cols_ext = EXT_CW'(COLS_S1);
         end
         3'd2: begin
            rows_ext = EXT_CW'(ROWS_S2);
            cols_ext = EXT_CW'(COLS_S2);
         end
         3'd3: begin
            rows_ext = EXT_CW'(ROWS_S3);
            cols_ext = EXT_CW'(COLS_S3);
         end
         default: begin
            rows_ext = EXT_CW'(ROWS_S4);
            cols_ext = EXT_CW'(COLS_S4);
         end
      endcase
   end

   assign stat.range_ok = (MAP_CW'(map_ff) < MAP_CW'(OUT_MAPS)) &&
                          (EXT_CW'(row_ff) < rows_ext) &&
                          (EXT_CW'(col_ff) < cols_ext);
   assign stat.pipe_busy = rd_vld_ff || mul_vld_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // request capture and setup
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         map_ff <= req_out_map;
         row_ff <= req_out_row;
         col_ff <= req_out_col;
      end
      if (cmd.setup) begin
         srow_ff <= cle_pkg::SCALED_W'(eff_stride) * cle_pkg::SCALED_W'(row_ff);
         scol_ff <= cle_pkg::SCALED_W'(eff_stride) * cle_pkg::SCALED_W'(col_ff);
         ok_ff   <= stat.range_ok;
      end
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.load_pixel && (32'(req_address) < 32'(IN_DEPTH))) begin
         in_mem[req_address[IN_AW-1:0]] <= req_value;
      end
      if (cmd.issue) begin
         x_ff <= in_mem[ia_ff[IN_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_weight && (32'(req_address) < 32'(WGT_DEPTH))) begin
         wgt_mem[req_address[WGT_AW-1:0]] <= req_value;
      end
      if (cmd.issue) begin
         w_ff <= wgt_mem[wa_ff[WGT_AW-1:0]];
      end
   end

   // address pointers
   always_comb begin
      ia_in = ia_ff;
      wa_in = wa_ff;
      if (cmd.base) begin
         ia_in = IN_PW'(srow_ff) * IN_PW'(IN_COLS) + IN_PW'(scol_ff);
         wa_in = WGT_PW'(map_ff) * WGT_PW'(TAPS);
      end else if (cmd.issue) begin
         wa_in = wa_ff + WGT_PW'(1);
         case (cmd.step)
            cle_pkg::STEP_NEXT_ROW:  ia_in = ia_ff + IN_PW'(ROW_JUMP);
            cle_pkg::STEP_NEXT_CHAN: ia_in = ia_ff + IN_PW'(CHAN_JUMP);
            default:                 ia_in = ia_ff + IN_PW'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ia_ff <= ia_in;
      wa_ff <= wa_in;
   end

   // multiply-accumulate, wrapping at DATA_BITS
   assign product = 32'(x_ff) * 32'(w_ff);
   assign acc_in  = cmd.setup ? '0 : (mul_vld_ff ? acc_ff + prod_ff : acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
      if (rd_vld_ff) prod_ff <= DATA_BITS'(product);
      acc_ff <= acc_in;
   end

   // sign-extend from DATA_BITS, keep the low word
   assign acc_wide = 32'($signed(acc_ff));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_result_ff <= ok_ff ? acc_wide[cle_pkg::WORD_W-1:0] : '0;
         rsp_status_ff <= ok_ff ? cle_pkg::STATUS_OK : cle_pkg::STATUS_RANGE;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/conv_layer_engine.sv =====
// conv_layer_engine: top level of the convolution-layer engine.
// Depends on cle_pkg, cle_if (channel interfaces), cle_ctrl and cle_datapath.

// Convolution-layer engine. Requests arrive on req_chan: req_type 0 stores a
// pixel word at a flat input-store address ((ch*IN_ROWS + row)*IN_COLS + col),
// req_type 1 stores a weight word at ((map*IN_CHANNELS + ch)*KERNEL + krow)*
// KERNEL + kcol, req_type 2 computes one output element (out_map, out_row,
// out_col). Loads outside a store and type 3 are dropped without a response.
// Each compute returns one transfer on rsp_chan: the DATA_BITS-wrapped sum of
// weight*pixel over all channels and kernel taps, sign-extended to 16 bits, or
// result 0 with status 1 when the coordinate lies outside the output map for
// the current stride. A compute runs one multiply-accumulate per cycle
// through a single MAC with one read port per store, so it holds the request
// channel through setup, the tap walk, the MAC pipe drain and the finish
// step; an out-of-range compute holds it through setup and finish only.
// Either one waits in its finish step while an earlier response is still
// unclaimed. The response sits in an output register, so new requests are
// taken while it waits. Stride is written through csr_we/csr_wdata only
// while idle, a rule the user must keep: the block itself does not enforce it.
// 0 acts as 1 and values above 4 act as 4. Both stores are uninitialized after reset.

module conv_layer_engine #(
   parameter int IN_CHANNELS = 16,
   parameter int OUT_MAPS    = 16,
   parameter int KERNEL      = 3,
   parameter int IN_ROWS     = 32,
   parameter int IN_COLS     = 32,
   parameter int DATA_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [cle_pkg::STRIDE_W-1:0]  csr_wdata,
   cle_req_if.sink                       req_chan,
   cle_rsp_if.source                     rsp_chan
);

   cle_pkg::cmd_type  cmd;
   cle_pkg::stat_type stat;

   // sequencer: handshake on the request side, tap walk, finish
   cle_ctrl #(
      .IN_CHANNELS (IN_CHANNELS),
      .KERNEL      (KERNEL)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores, pointers, MAC pipe, response register
   cle_datapath #(
      .IN_CHANNELS (IN_CHANNELS),
      .OUT_MAPS    (OUT_MAPS),
      .KERNEL      (KERNEL),
      .IN_ROWS     (IN_ROWS),
      .IN_COLS     (IN_COLS),
      .DATA_BITS   (DATA_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_address (req_chan.address),
      .req_value   (req_chan.value),
      .req_out_map (req_chan.out_map),
      .req_out_row (req_chan.out_row),
      .req_out_col (req_chan.out_col),
      .rsp_valid   (rsp_chan.valid),
      .rsp_result  (rsp_chan.result),
      .rsp_status  (rsp_chan.status),
      .rsp_ready   (rsp_chan.ready)
   );

endmodule

// ===== bench/conv_layer_engine_checker.sv =====
`timescale 1ns / 100ps
// conv_layer_engine_checker: snoops the request, response and stride ports,
// predicts each compute response from its own stores and checks it in order.
// Depends on cle_pkg and the channel interfaces in cle_if.

module conv_layer_engine_checker
   import cle_pkg::*;
#(
   parameter int IN_CHANNELS = 16,
   parameter int OUT_MAPS    = 16,
   parameter int KERNEL      = 3,
   parameter int IN_ROWS     = 32,
   parameter int IN_COLS     = 32,
   parameter int DATA_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [STRIDE_W-1:0] csr_wdata,
   cle_req_if                  req_mon,
   cle_rsp_if                  rsp_mon,
   input  logic                end_check,
   output int unsigned         fail_count,
   output int unsigned         pending_count,
   output int unsigned         checked_count,
   output int unsigned         range_count
);

   localparam int PIXEL_DEPTH  = IN_CHANNELS * IN_ROWS * IN_COLS;
   localparam int WEIGHT_DEPTH = OUT_MAPS * IN_CHANNELS * KERNEL * KERNEL;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              status;
   } conv_answer_type;

   logic [WORD_W-1:0]   pixel_mem [PIXEL_DEPTH];
   logic [WORD_W-1:0]   weight_mem [WEIGHT_DEPTH];
   logic [STRIDE_W-1:0] stride_reg;
   conv_answer_type     answer_q [$];
   bit                  leftover_seen;

   task automatic report_mismatch(string msg);
      $display("%0t ns  MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   // 0 behaves as 1, anything above the max clamps to the max
   function automatic int unsigned eff_stride(logic [STRIDE_W-1:0] s);
      if (s < STRIDE_MIN) return 32'(STRIDE_MIN);
      if (s > STRIDE_MAX) return 32'(STRIDE_MAX);
      return 32'(s);
   endfunction

   function automatic int unsigned out_extent(int unsigned len, int unsigned st);
      if (KERNEL > len) return 0;
      return (len - KERNEL) / st + 1;
   endfunction

   // Sum of weight*pixel over channels and taps, wrapped at DATA_BITS
   function automatic logic [WORD_W-1:0] conv_element(int unsigned map, int unsigned row,
                                                      int unsigned col, int unsigned st);
      logic [DATA_BITS-1:0] acc;
      logic signed [31:0]   px;
      logic signed [31:0]   wt;
      logic signed [63:0]   prod;
      logic signed [63:0]   wide;
      int unsigned          pa;
      int unsigned          wa;
      acc = '0;
      for (int unsigned c = 0; c < IN_CHANNELS; c++) begin
         for (int unsigned ki = 0; ki < KERNEL; ki++) begin
            for (int unsigned kj = 0; kj < KERNEL; kj++) begin
               pa = (c * IN_ROWS + st * row + ki) * IN_COLS + st * col + kj;
               wa = ((map * IN_CHANNELS + c) * KERNEL + ki) * KERNEL + kj;
               px = 0;
               wt = 0;
               if (pa < PIXEL_DEPTH) px = 32'($signed(pixel_mem[pa]));
               if (wa < WEIGHT_DEPTH) wt = 32'($signed(weight_mem[wa]));
               prod = 64'(px) * 64'(wt);
               acc  = acc + prod[DATA_BITS-1:0];
            end
         end
      end
      wide = 64'($signed(acc));
      return wide[WORD_W-1:0];
   endfunction

   always @(posedge clock) begin
      conv_answer_type want;
      int unsigned     st;
      if (reset) begin
         stride_reg    = STRIDE_RESET;
         answer_q.delete();
         leftover_seen = 1'b0;
         fail_count    = 0;
         checked_count = 0;
         range_count   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding (result %0d)",
                                         rsp_mon.result));
            end else begin
               want = answer_q.pop_front();
               if (rsp_mon.result !== want.result)
                  report_mismatch($sformatf("result %0d, predicted %0d",
                                            rsp_mon.result, $signed(want.result)));
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status %0b, predicted %0b",
                                            rsp_mon.status, want.status));
               checked_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_LOAD_PIXEL: begin
                  if (req_mon.address < PIXEL_DEPTH) pixel_mem[req_mon.address] = req_mon.value;
               end
               REQ_LOAD_WEIGHT: begin
                  if (req_mon.address < WEIGHT_DEPTH)
                     weight_mem[req_mon.address] = req_mon.value;
               end
               REQ_COMPUTE: begin
                  st = eff_stride(stride_reg);
                  if (req_mon.out_map >= OUT_MAPS || req_mon.out_row >= out_extent(IN_ROWS, st)
                      || req_mon.out_col >= out_extent(IN_COLS, st)) begin
                     want.result = '0;
                     want.status = STATUS_RANGE;
                     range_count++;
                  end else begin
                     want.result = conv_element(32'(req_mon.out_map), 32'(req_mon.out_row),
                                                32'(req_mon.out_col), st);
                     want.status = STATUS_OK;
                  end
                  answer_q.push_back(want);
               end
               default: ;
            endcase
         end
         // stride is only written while idle, after any compute it could affect
         if (csr_we) stride_reg = csr_wdata;
         if (end_check && !leftover_seen && answer_q.size() != 0) begin
            report_mismatch($sformatf("%0d predicted responses never arrived",
                                      answer_q.size()));
            leftover_seen = 1'b1;
         end
      end
      pending_count = answer_q.size();
   end

endmodule

// ===== bench/conv_layer_engine_tb.sv =====
`timescale 1ns / 100ps
// conv_layer_engine_tb: stimulus and verdict for conv_layer_engine.
// Depends on cle_pkg, cle_if, the engine RTL and conv_layer_engine_checker.

module conv_layer_engine_tb;
   import cle_pkg::*;

   localparam int IN_CHANNELS = 16;
   localparam int OUT_MAPS    = 16;
   localparam int KERNEL      = 3;
   localparam int IN_ROWS     = 32;
   localparam int IN_COLS     = 32;
   localparam int DATA_BITS   = 16;

   localparam int PIXEL_DEPTH  = IN_CHANNELS * IN_ROWS * IN_COLS;
   localparam int TAPS         = IN_CHANNELS * KERNEL * KERNEL;
   localparam int WEIGHT_DEPTH = OUT_MAPS * TAPS;

   // A corner of the pixel store and the weights of the last map are filled,
   // other entries get scattered loads; in-map computes stay on that footprint.
   localparam int FILL_ROWS   = KERNEL;
   localparam int FILL_COLS   = KERNEL + 1;
   localparam int WEIGHT_BASE = (OUT_MAPS - 1) * TAPS;

   // type 3 is unused by the engine and must be swallowed
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 80;
   localparam int NUM_PHASES   = 8;
   // one MAC per tap plus pipeline overhead
   localparam int COMPUTE_CYCLES = IN_CHANNELS * KERNEL * KERNEL + 6;
   localparam int SETTLE_CYCLES  = COMPUTE_CYCLES + 16;
   // hard-stop time limit in ns
   localparam longint LIMIT_NS = 64'd20 * 64'd1_000_000;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [STRIDE_W-1:0] csr_wdata;
   logic                end_check;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned range_count;

   bit          quiet;        // no idling on either side once set
   int unsigned stall_left;
   int unsigned cur_stride;     // effective stride, used to aim coordinates
   int unsigned pixel_loads;
   int unsigned weight_loads;

   logic [STRIDE_W-1:0] stride_plan [NUM_PHASES] =
      '{3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1};

   cle_req_if req_chan ();
   cle_rsp_if rsp_chan ();

   conv_layer_engine #(
      .IN_CHANNELS (IN_CHANNELS),
      .OUT_MAPS    (OUT_MAPS),
      .KERNEL      (KERNEL),
      .IN_ROWS     (IN_ROWS),
      .IN_COLS     (IN_COLS),
      .DATA_BITS   (DATA_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   conv_layer_engine_checker #(
      .IN_CHANNELS (IN_CHANNELS),
      .OUT_MAPS    (OUT_MAPS),
      .KERNEL      (KERNEL),
      .IN_ROWS     (IN_ROWS),
      .IN_COLS     (IN_COLS),
      .DATA_BITS   (DATA_BITS)
   ) conv_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .end_check     (end_check),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .range_count   (range_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d responses outstanding", pending_count);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: ready drops in random bursts, never once quiet.
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 6);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic logic [ADDR_W-1:0] pixel_addr(int unsigned ch, int unsigned row,
                                                    int unsigned col);
      return ADDR_W'((ch * IN_ROWS + row) * IN_COLS + col);
   endfunction

   // One request transfer. Called at a falling edge, returns at the falling
   // edge after the accepting rising edge with valid still high, so the
   // caller either drives the next item or drops valid in that same step.
   task automatic push_request(logic [TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [WORD_W-1:0] word, logic [MAP_W-1:0] map,
                               logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.address  <= addr;
      req_chan.value    <= word;
      req_chan.out_map  <= map;
      req_chan.out_row  <= row;
      req_chan.out_col  <= col;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (kind == REQ_LOAD_PIXEL) pixel_loads++;
      if (kind == REQ_LOAD_WEIGHT && addr < WEIGHT_DEPTH) weight_loads++;
   endtask

   // Loads ignore the coordinate fields, so they carry noise there
   task automatic push_load(logic [TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            logic [WORD_W-1:0] word);
      push_request(kind, addr, word, MAP_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
   endtask

   // Computes ignore address and value, likewise
   task automatic push_compute(logic [MAP_W-1:0] map, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col);
      push_request(REQ_COMPUTE, ADDR_W'($urandom), WORD_W'($urandom), map, row, col);
   endtask

   // Drop valid, wait for every predicted response, then let any compute
   // still in flight finish before the stride may change.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_stride(logic [STRIDE_W-1:0] s);
      csr_we    <= 1'b1;
      csr_wdata <= s;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (s < STRIDE_MIN) cur_stride = 32'(STRIDE_MIN);
      else if (s > STRIDE_MAX) cur_stride = 32'(STRIDE_MAX);
      else cur_stride = 32'(s);
   endtask

   // One random item. In-map computes use the loaded corner of the last map;
   // loads mostly refresh that footprint, now and then land anywhere.
   task automatic random_item();
      int unsigned pick;
      int unsigned rows;
      int unsigned cols;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      rows = (IN_ROWS - KERNEL) / cur_stride + 1;
      cols = (IN_COLS - KERNEL) / cur_stride + 1;
      if (pick < 30) begin
         col = (cur_stride == 1) ? COL_W'($urandom_range(0, FILL_COLS - KERNEL)) : '0;
         push_compute(MAP_W'(OUT_MAPS - 1), '0, col);
      end else if (pick < 45) begin
         // off the map in one direction, anything in the other
         if ($urandom_range(0, 1) == 0) begin
            row = ROW_W'($urandom_range(rows, (1 << ROW_W) - 1));
            col = COL_W'($urandom);
         end else begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom_range(cols, (1 << COL_W) - 1));
         end
         push_compute(MAP_W'($urandom), row, col);
      end else if (pick < 70) begin
         if ($urandom_range(0, 7) == 0) addr = ADDR_W'($urandom);
         else addr = pixel_addr($urandom_range(0, IN_CHANNELS - 1),
                                $urandom_range(0, FILL_ROWS - 1),
                                $urandom_range(0, FILL_COLS - 1));
         push_load(REQ_LOAD_PIXEL, addr, WORD_W'($urandom));
      end else if (pick < 93) begin
         if ($urandom_range(0, 7) == 0) addr = ADDR_W'($urandom);
         else addr = ADDR_W'(WEIGHT_BASE + $urandom_range(0, TAPS - 1));
         push_load(REQ_LOAD_WEIGHT, addr, WORD_W'($urandom));
      end else begin
         push_request(REQ_UNUSED, ADDR_W'($urandom), WORD_W'($urandom), MAP_W'($urandom),
                      ROW_W'($urandom), COL_W'($urandom));
      end
   endtask

   initial begin
      int unsigned rows;
      int unsigned cols;

      // every input known from time zero
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = STRIDE_RESET;
      end_check         = 1'b0;
      quiet             = 1'b0;
      stall_left        = 0;
      cur_stride        = 32'(STRIDE_RESET);
      pixel_loads       = 0;
      weight_loads      = 0;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_LOAD_PIXEL;
      req_chan.address  = '0;
      req_chan.value    = '0;
      req_chan.out_map  = '0;
      req_chan.out_row  = '0;
      req_chan.out_col  = '0;
      rsp_chan.ready    = 1'b1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the top-left corner of every channel and all weights of the last
      // map, so no in-map compute at (0,0), or (0,1) at stride 1, ever reads
      // a never-written entry.
      for (int ch = 0; ch < IN_CHANNELS; ch++)
         for (int r = 0; r < FILL_ROWS; r++)
            for (int c = 0; c < FILL_COLS; c++)
               push_load(REQ_LOAD_PIXEL, pixel_addr(ch, r, c), WORD_W'($urandom));
      for (int t = 0; t < TAPS; t++)
         push_load(REQ_LOAD_WEIGHT, ADDR_W'(WEIGHT_BASE + t), WORD_W'($urandom));

      // Directed, reset stride: word extremes in the loaded footprint and at
      // the last entry of each store, loads past the weight store and the
      // unused request type (all must be dropped), then computes over the loaded
      // footprint plus coordinates just outside the map.
      push_load(REQ_LOAD_PIXEL, '0, 16'h7FFF);
      push_load(REQ_LOAD_PIXEL, ADDR_W'(1), 16'hFFFF);
      push_load(REQ_LOAD_PIXEL, ADDR_W'(PIXEL_DEPTH - 1), 16'h8000);
      push_load(REQ_LOAD_WEIGHT, ADDR_W'(WEIGHT_BASE), 16'h8000);
      push_load(REQ_LOAD_WEIGHT, ADDR_W'(WEIGHT_BASE + 1), 16'hFFFF);
      push_load(REQ_LOAD_WEIGHT, ADDR_W'(WEIGHT_DEPTH - 1), 16'h8000);
      push_load(REQ_LOAD_WEIGHT, ADDR_W'(WEIGHT_DEPTH), 16'h0000);
      push_load(REQ_LOAD_WEIGHT, '1, 16'h0000);
      push_request(REQ_UNUSED, '0, 16'h0000, '0, '0, '0);
      push_compute(MAP_W'(OUT_MAPS - 1), '0, '0);
      push_compute(MAP_W'(OUT_MAPS - 1), '0, COL_W'(1));
      push_compute(MAP_W'(OUT_MAPS - 1), ROW_W'(30), '0);
      push_compute('0, '0, COL_W'(30));
      push_compute('1, '1, '1);
      push_load(REQ_LOAD_PIXEL, '0, 16'h0000);
      push_compute(MAP_W'(OUT_MAPS - 1), '0, '0);

      // Random phases, one per stride setting; the plan covers zero, every
      // legal value and the clamped values above the max.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_stride(stride_plan[p]);
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         rows = (IN_ROWS - KERNEL) / cur_stride + 1;
         cols = (IN_COLS - KERNEL) / cur_stride + 1;
         // loaded corner for this stride, then the first row/col outside the map
         push_compute(MAP_W'(OUT_MAPS - 1), '0, '0);
         push_compute(MAP_W'($urandom), ROW_W'(rows), COL_W'($urandom_range(0, cols - 1)));
         push_compute(MAP_W'($urandom), ROW_W'($urandom_range(0, rows - 1)), COL_W'(cols));
         for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) random_item();
      end

      settle();
      end_check <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Covered %0d pixel and %0d weight loads, %0d compute responses checked",
               pixel_loads, weight_loads, checked_count);
      $display("(%0d outside the map) over %0d stride settings with random stalls",
               range_count, NUM_PHASES + 1);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== conv_layer_engine.f =====
rtl/cle_pkg.sv
rtl/cle_if.sv
rtl/cle_ctrl.sv
rtl/cle_datapath.sv
rtl/conv_layer_engine.sv
bench/conv_layer_engine_checker.sv
bench/conv_layer_engine_tb.sv
